[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/kic_pkg.sv]
// Shared types and key codes for the keypad integer calculator.
package kic_pkg;

	localparam int KIND_W  = 3;
	localparam int DIGIT_W = 4;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	localparam kind_t KIND_DIGIT  = 3'd0;
	localparam kind_t KIND_ADD    = 3'd1;
	localparam kind_t KIND_SUB    = 3'd2;
	localparam kind_t KIND_MUL    = 3'd3;
	localparam kind_t KIND_DIV    = 3'd4;
	localparam kind_t KIND_EQUALS = 3'd5;
	localparam kind_t KIND_CLEAR  = 3'd6;
	// pending operator code before any operator is typed
	localparam kind_t OP_NONE     = 3'd0;

	localparam digit_t DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

[hw/rtl/kic_entry.sv]
// Decimal entry register: one digit per cycle, with overflow flag.
module kic_entry #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   dig_en,
	input  kic_pkg::digit_t        digit,
	input  logic                   clear,
	output logic [DATA_WIDTH-2:0]  entry,
	output logic                   ovf
);

	localparam int W = DATA_WIDTH;

	logic [W-2:0] entry_q;
	logic         ovf_q;
	logic [W+2:0] ext;
	logic [W+2:0] next;
	logic         too_big;

	// entry * 10 + digit, kept wide enough to see the overflow
	assign ext     = {4'b0, entry_q};
	assign next    = (ext << 3) + (ext << 1) + (W+3)'(digit);
	assign too_big = |next[W+2:W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			ovf_q   <= 1'b0;
		end else if (clear) begin
			entry_q <= '0;
			ovf_q   <= 1'b0;
		end else if (dig_en && (digit <= kic_pkg::DIGIT_MAX) && !ovf_q) begin
			if (too_big) begin
				ovf_q <= 1'b1;
			end else begin
				entry_q <= next[W-2:0];
			end
		end
	end

	assign entry = entry_q;
	assign ovf   = ovf_q;

endmodule

[hw/rtl/kic_alu.sv]
// Bit-serial multiplier and restoring divider, one bit per cycle.
module kic_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kic_pkg::alu_req_t     req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output kic_pkg::alu_rsp_t     rsp,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic          busy_q, fin_q, done_q, div_q, neg_q, zero_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q;    // multiplicand, or dividend shifting into quotient
	logic [W-1:0]  y_q;    // multiplier, or divisor magnitude
	logic [W:0]    acc_q;  // partial product, or remainder
	logic [W-1:0]  res_q;

	logic [W:0]    trial;
	logic          ge;
	logic [W:0]    div_rem;
	logic [W-1:0]  mul_sum;
	logic [W-1:0]  a_mag, b_mag, x_neg;

	assign trial   = {acc_q[W-1:0], x_q[W-1]};
	assign ge      = trial >= {1'b0, y_q};
	assign div_rem = ge ? (trial - {1'b0, y_q}) : trial;
	assign mul_sum = acc_q[W-1:0] + (y_q[0] ? x_q : '0);
	assign a_mag   = a[W-1] ? (~a + 1'b1) : a;
	assign b_mag   = b[W-1] ? (~b + 1'b1) : b;
	assign x_neg   = ~x_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q <= LAST;
			div_q <= req.is_div;
			acc_q <= '0;
			if (req.is_div) begin
				x_q    <= a_mag;
				y_q    <= b_mag;
				neg_q  <= a[W-1] ^ b[W-1];
				zero_q <= (b == '0);
			end else begin
				x_q    <= a;
				y_q    <= b;
				neg_q  <= 1'b0;
				zero_q <= 1'b0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (div_q) begin
				acc_q <= div_rem;
				x_q   <= {x_q[W-2:0], ge};
			end else begin
				acc_q <= {1'b0, mul_sum};
				x_q   <= {x_q[W-2:0], 1'b0};
				y_q   <= {1'b0, y_q[W-1:1]};
			end
		end else if (fin_q) begin
			if (!div_q) begin
				res_q <= acc_q[W-1:0];
			end else if (zero_q) begin
				res_q <= '0;
			end else begin
				res_q <= neg_q ? x_neg : x_q;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = done_q && zero_q;
	assign result       = res_q;

endmodule

[hw/rtl/keypad_integer_calculator.sv]
// Keypad four-function integer calculator, top level.
// Input channel (in_valid/in_ready, kind, digit) takes one key per transaction:
// a digit, add, subtract, multiply, divide, equals or clear. Digits build a
// decimal entry; an operator folds the entry into the accumulator with the
// pending operator, left to right, and becomes the new pending operator.
// Equals finishes the chain and sends one transaction on the output channel
// (out_valid/out_ready, value, divide_by_zero, entry_too_large), then clears.
// Digits, clear and operators whose pending operator is none, add or
// subtract are taken without stalling the input. With multiply or divide
// pending, the shared bit-serial unit runs one bit a cycle, and in_ready
// stays low until its result is in the accumulator. Equals then passes
// through a send state that loads the output register; out_valid rises as it loads.
// The output register holds a result while the receiver stalls; new keys keep
// being taken meanwhile, and only a second equals waits for it to drain.
// Reset (arst_n low) clears accumulator, entry, flags and the output valid.
module keypad_integer_calculator #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             kind,
	input  logic [3:0]             digit,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [31:0]     value,
	output logic                   divide_by_zero,
	output logic                   entry_too_large
);

	localparam int W = DATA_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t                      state_q;
	logic [W-1:0]                acc_q;
	kic_pkg::kind_t              pend_q;
	logic                        eq_q, zdiv_q, ovf_q;
	logic                        out_valid_q;
	logic signed [31:0]          value_q;
	logic                        dz_q, etl_q;

	logic [W-2:0]                entry;
	logic                        entry_ovf;
	logic                        in_fire, op_key, take, use_alu;
	logic [W-1:0]                operand, quick, alu_res;
	kic_pkg::alu_req_t           alu_req;
	kic_pkg::alu_rsp_t           alu_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign op_key   = (kind == kic_pkg::KIND_ADD) || (kind == kic_pkg::KIND_SUB) ||
	                  (kind == kic_pkg::KIND_MUL) || (kind == kic_pkg::KIND_DIV) ||
	                  (kind == kic_pkg::KIND_EQUALS);
	assign take     = in_fire && op_key;
	assign use_alu  = (pend_q == kic_pkg::KIND_MUL) || (pend_q == kic_pkg::KIND_DIV);
	assign operand  = entry_ovf ? '0 : {1'b0, entry};

	always_comb begin
		case (pend_q)
			kic_pkg::KIND_ADD: quick = acc_q + operand;
			kic_pkg::KIND_SUB: quick = acc_q - operand;
			default:           quick = operand;
		endcase
	end

	assign alu_req.start  = take && use_alu;
	assign alu_req.is_div = (pend_q == kic_pkg::KIND_DIV);

	kic_entry #(.DATA_WIDTH(W)) u_entry (
		.clk    (clk),
		.arst_n (arst_n),
		.dig_en (in_fire && (kind == kic_pkg::KIND_DIGIT)),
		.digit  (digit),
		.clear  (take || (in_fire && (kind == kic_pkg::KIND_CLEAR))),
		.entry  (entry),
		.ovf    (entry_ovf)
	);

	kic_alu #(.DATA_WIDTH(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (acc_q),
		.b      (operand),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pend_q      <= kic_pkg::OP_NONE;
			eq_q        <= 1'b0;
			zdiv_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// ST_SEND drives out_valid_q itself
			if (out_valid_q && out_ready && (state_q != ST_SEND)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (kind == kic_pkg::KIND_CLEAR)) begin
						acc_q  <= '0;
						pend_q <= kic_pkg::OP_NONE;
						zdiv_q <= 1'b0;
						ovf_q  <= 1'b0;
					end else if (take) begin
						ovf_q  <= ovf_q | entry_ovf;
						eq_q   <= (kind == kic_pkg::KIND_EQUALS);
						pend_q <= kind;
						if (use_alu) begin
							state_q <= ST_CALC;
						end else begin
							acc_q <= quick;
							if (kind == kic_pkg::KIND_EQUALS) begin
								state_q <= ST_SEND;
							end
						end
					end
				end
				ST_CALC: begin
					if (alu_rsp.done) begin
						acc_q   <= alu_res;
						zdiv_q  <= zdiv_q | alu_rsp.div_zero;
						state_q <= eq_q ? ST_SEND : ST_IDLE;
					end
				end
				ST_SEND: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						pend_q      <= kic_pkg::OP_NONE;
						zdiv_q      <= 1'b0;
						ovf_q       <= 1'b0;
						eq_q        <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload, loaded together with out_valid
	always_ff @(posedge clk) begin
		if ((state_q == ST_SEND) && (!out_valid_q || out_ready)) begin
			value_q <= 32'($signed(acc_q));
			dz_q    <= zdiv_q;
			etl_q   <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign value           = value_q;
	assign divide_by_zero  = dz_q;
	assign entry_too_large = etl_q;

endmodule

[hw/rtl/kic_checker.sv]
// Port-level checker for the keypad calculator and its bind.
`include "assert_macros.svh"

module kic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic        divide_by_zero,
	input logic        entry_too_large
);

	logic        eq_fire;
	logic        dig_fire;
	logic        out_stall;
	logic [33:0] payload;

	assign eq_fire   = in_valid && in_ready && (kind == kic_pkg::KIND_EQUALS);
	assign dig_fire  = in_valid && in_ready && (kind == kic_pkg::KIND_DIGIT);
	assign out_stall = out_valid && !out_ready;
	assign payload   = {value, divide_by_zero, entry_too_large};

	`KIC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid, "out_valid dropped early")

	`KIC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(payload), "payload changed")

	`KIC_ASSERT_NEXT(a_equals_busy, clk, arst_n, eq_fire, !in_ready, "equals did not stall input")

	`KIC_ASSERT_NEXT(a_digit_fast, clk, arst_n, dig_fire, in_ready, "digit key stalled input")

	`KIC_ASSERT_NOW(a_result_source, clk, arst_n, $rose(out_valid), !$past(in_ready), "stray result")

endmodule

bind keypad_integer_calculator kic_checker u_kic_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.kind            (kind),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.value           (value),
	.divide_by_zero  (divide_by_zero),
	.entry_too_large (entry_too_large)
);

[tb/keypad_integer_calculator_tb.sv]
// Self-checking testbench for keypad_integer_calculator: directed key table, then random chains.
`timescale 1ns / 100ps

module keypad_integer_calculator_tb;

	localparam int              CLK_HALF     = 4;
	localparam int              RESET_CYCLES = 5;
	localparam int              RANDOM_KEYS  = 600;
	localparam int              DRAIN_CYCLES = 80;
	localparam int              HOLD_AFTER   = 8;
	localparam int              LONG_HOLD    = 600;
	localparam int              MAX_REPORTS  = 10;
	localparam logic [31:0]     ENTRY_MAX    = 32'h7FFF_FFFF;
	// codes the block has to drop on the floor
	localparam kic_pkg::kind_t  KIND_UNUSED  = 3'd7;
	localparam kic_pkg::digit_t DIGIT_BAD    = 4'd15;

	typedef struct packed {
		logic [31:0] value;
		logic        divide_by_zero;
		logic        entry_too_large;
	} calc_result_t;

	typedef struct packed {
		kic_pkg::kind_t  kind;
		kic_pkg::digit_t digit;
		logic            typed;
		calc_result_t    want;
	} key_row_t;

	logic               clk       = 1'b0;
	logic               arst_n;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	kic_pkg::kind_t     kind      = kic_pkg::KIND_DIGIT;
	kic_pkg::digit_t    digit     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] value;
	logic               divide_by_zero;
	logic               entry_too_large;

	// calculator state as predicted
	logic [31:0]    calc_acc;
	kic_pkg::kind_t calc_op;
	logic [30:0]    calc_entry;
	logic           calc_entry_big;
	logic           calc_div0;
	logic           calc_big_seen;

	calc_result_t chain_results[$];
	key_row_t     key_table[$];
	int           errors       = 0;
	int           keys_done    = 0;
	int           keys_sent    = 0;
	int           results_seen = 0;

	keypad_integer_calculator #(
		.DATA_WIDTH(32)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.digit          (digit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.divide_by_zero (divide_by_zero),
		.entry_too_large(entry_too_large)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void calc_reset();
		calc_acc       = '0;
		calc_op        = kic_pkg::OP_NONE;
		calc_entry     = '0;
		calc_entry_big = 1'b0;
		calc_div0      = 1'b0;
		calc_big_seen  = 1'b0;
	endfunction

	// truncating signed divide done on magnitudes
	function automatic logic [31:0] calc_divide(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] mag_a, mag_b, quo;
		mag_a = a[31] ? -a : a;
		mag_b = b[31] ? -b : b;
		if (mag_b == '0) begin
			calc_div0 = 1'b1;
			return '0;
		end
		quo = mag_a / mag_b;
		return (a[31] != b[31]) ? -quo : quo;
	endfunction

	function automatic logic [31:0] calc_apply(input kic_pkg::kind_t op, input logic [31:0] a,
			input logic [31:0] b);
		case (op)
			kic_pkg::KIND_ADD: return a + b;
			kic_pkg::KIND_SUB: return a - b;
			kic_pkg::KIND_MUL: return a * b;
			kic_pkg::KIND_DIV: return calc_divide(a, b);
			default:           return b;
		endcase
	endfunction

	function automatic logic [31:0] calc_take_entry();
		logic [31:0] operand;
		operand = {1'b0, calc_entry};
		if (calc_entry_big) begin
			calc_big_seen = 1'b1;
			operand       = '0;
		end
		calc_entry     = '0;
		calc_entry_big = 1'b0;
		return operand;
	endfunction

	function automatic void calc_key(input kic_pkg::kind_t k, input kic_pkg::digit_t d,
			output logic got, output calc_result_t res);
		got = 1'b0;
		res = '0;
		case (k)
			kic_pkg::KIND_DIGIT: begin
				if (d <= kic_pkg::DIGIT_MAX && !calc_entry_big) begin
					if ({1'b0, calc_entry} > (ENTRY_MAX - 32'(d)) / 32'd10)
						calc_entry_big = 1'b1;
					else
						calc_entry = calc_entry * 31'd10 + 31'(d);
				end
			end
			kic_pkg::KIND_ADD, kic_pkg::KIND_SUB, kic_pkg::KIND_MUL, kic_pkg::KIND_DIV: begin
				calc_acc = calc_apply(calc_op, calc_acc, calc_take_entry());
				calc_op  = k;
			end
			kic_pkg::KIND_EQUALS: begin
				res.value           = calc_apply(calc_op, calc_acc, calc_take_entry());
				res.divide_by_zero  = calc_div0;
				res.entry_too_large = calc_big_seen;
				got                 = 1'b1;
				calc_reset();
			end
			kic_pkg::KIND_CLEAR: calc_reset();
			default: ;
		endcase
	endfunction

	function automatic void add_row(input kic_pkg::kind_t k, input kic_pkg::digit_t d,
			input logic typed = 1'b0, input logic [31:0] v = '0, input logic dz = 1'b0,
			input logic big = 1'b0);
		key_row_t row;
		row.kind  = k;
		row.digit = d;
		row.typed = typed;
		row.want  = {v, dz, big};
		key_table.push_back(row);
	endfunction

	function automatic void report_mismatch(input string what, input calc_result_t want,
			input calc_result_t got);
		if (errors < MAX_REPORTS)
			$display("mismatch, %s: expected value %0d dz %0b big %0b, got value %0d dz %0b big %0b",
				what, $signed(want.value), want.divide_by_zero, want.entry_too_large,
				$signed(got.value), got.divide_by_zero, got.entry_too_large);
		errors++;
	endfunction

	// one key transaction; the prediction is made at the accepting edge
	task automatic press(input kic_pkg::kind_t k, input kic_pkg::digit_t d,
			input logic typed = 1'b0, input calc_result_t want = '0);
		int           gap;
		logic         got;
		calc_result_t res;
		gap = (keys_sent % 80 < 20) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		digit    <= d;
		do @(posedge clk); while (!in_ready);
		keys_sent++;
		calc_key(k, d, got, res);
		if (got)
			chain_results.push_back(typed ? want : res);
		if (!((k == kic_pkg::KIND_DIGIT && d > kic_pkg::DIGIT_MAX) || k == KIND_UNUSED))
			keys_done++;
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 1))
			press(KIND_UNUSED, kic_pkg::digit_t'($urandom_range(0, 15)));
		else
			press(kic_pkg::KIND_DIGIT,
				kic_pkg::digit_t'($urandom_range(int'(kic_pkg::DIGIT_MAX) + 1, 15)));
	endtask

	// mostly short operands, sometimes empty, sometimes long enough to overflow
	task automatic send_operand();
		int pick, len;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = 0;
		else if (pick == 1)
			len = $urandom_range(9, 12);
		else
			len = $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_noise();
			press(kic_pkg::KIND_DIGIT,
				kic_pkg::digit_t'($urandom_range(0, int'(kic_pkg::DIGIT_MAX))));
		end
	endtask

	task automatic send_chain();
		int n_ops;
		n_ops = $urandom_range(0, 4);
		for (int i = 0; i <= n_ops; i++) begin
			send_operand();
			if (i < n_ops) begin
				if ($urandom_range(0, 31) == 0)
					press(kic_pkg::KIND_CLEAR, kic_pkg::digit_t'($urandom_range(0, 15)));
				else
					press(kic_pkg::kind_t'($urandom_range(int'(kic_pkg::KIND_ADD),
						int'(kic_pkg::KIND_DIV))),
						kic_pkg::digit_t'($urandom_range(0, 15)));
			end
		end
		if ($urandom_range(0, 15) == 0)
			press(kic_pkg::KIND_CLEAR, kic_pkg::digit_t'($urandom_range(0, 15)));
		else
			press(kic_pkg::KIND_EQUALS, kic_pkg::digit_t'($urandom_range(0, 15)));
	endtask

	initial begin : stimulus
		int max_digits[11] = '{0, 2, 1, 4, 7, 4, 8, 3, 6, 4, 7};
		arst_n <= 1'b0;
		calc_reset();

		// equals straight after reset: empty entry, no operator
		add_row(kic_pkg::KIND_EQUALS, 4'd0, 1'b1, 32'd0, 1'b0, 1'b0);
		// largest entry behind a leading zero, a bad digit, then wrap past the top
		foreach (max_digits[i])
			add_row(kic_pkg::KIND_DIGIT, kic_pkg::digit_t'(max_digits[i]));
		add_row(kic_pkg::KIND_DIGIT, DIGIT_BAD);
		add_row(kic_pkg::KIND_ADD, 4'd0);
		add_row(kic_pkg::KIND_DIGIT, 4'd1);
		add_row(kic_pkg::KIND_EQUALS, 4'd0, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
		// unused kind, then divide with empty operands
		add_row(KIND_UNUSED, 4'd9);
		add_row(kic_pkg::KIND_DIV, 4'd15);
		add_row(kic_pkg::KIND_EQUALS, 4'd0, 1'b1, 32'd0, 1'b1, 1'b0);
		// no precedence: 7 * 3 - 5, then a clear with nothing pending
		add_row(kic_pkg::KIND_DIGIT, 4'd7);
		add_row(kic_pkg::KIND_MUL, 4'd0);
		add_row(kic_pkg::KIND_DIGIT, 4'd3);
		add_row(kic_pkg::KIND_SUB, 4'd0);
		add_row(kic_pkg::KIND_DIGIT, 4'd5);
		add_row(kic_pkg::KIND_EQUALS, 4'd0);
		add_row(kic_pkg::KIND_CLEAR, 4'd0);
		// divisors are typed entries and never negative, so the
		// most-negative by minus one wrap cannot be reached from the keys

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (key_table[i])
			press(key_table[i].kind, key_table[i].digit, key_table[i].typed,
				key_table[i].want);

		keys_done = 0;
		while (keys_done < RANDOM_KEYS)
			send_chain();
		in_valid <= 1'b0;

		while (chain_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("keypad_integer_calculator_tb: PASS");
		else
			$display("keypad_integer_calculator_tb: FAIL");
		$finish;
	end

	initial begin : result_sink
		int           stall;
		logic         held;
		calc_result_t got, want;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			// one long hold-off so the output register fills and a second equals backs up
			if (!held && results_seen == HOLD_AFTER) begin
				stall = LONG_HOLD;
				held  = 1'b1;
			end else if (results_seen % 12 < 3)
				stall = 0;
			else
				stall = $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			got = {value, divide_by_zero, entry_too_large};
			if (chain_results.size() == 0)
				report_mismatch("no result expected", '0, got);
			else begin
				want = chain_results.pop_front();
				if (got.value !== want.value || got.divide_by_zero !== want.divide_by_zero ||
						got.entry_too_large !== want.entry_too_large)
					report_mismatch("wrong result", want, got);
			end
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("keypad_integer_calculator_tb: FAIL");
		$finish;
	end

endmodule
